FILE: hw/rtl/sgpg_pkg.sv
// Shared types, constants and helpers for the serpentine grid point generator.
// Used by every module under hw/rtl; depends on nothing.
`default_nettype none

package sgpg_pkg;

	localparam int MAX_ROWS        = 1024;
	localparam int MAX_COLUMNS     = 1024;
	localparam int COORD_WIDTH_DEF = 24;

	// register and output width of row/column counts
	localparam int CNT_W = 11;
	// zero-based grid index width
	localparam int IDX_W = $clog2((MAX_ROWS > MAX_COLUMNS) ? MAX_ROWS : MAX_COLUMNS);

	// factors: unsigned, 15 fraction bits, 1.0 = 32768
	localparam int FACTOR_W    = 16;
	localparam int FACTOR_FRAC = 15;
	localparam int FACTOR_HALF = 16384;

	localparam int JOB_DEPTH   = 2;
	localparam int CFG_INDEX_W = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ORIGIN,
		CFG_ROW_END,
		CFG_COLUMN_END,
		CFG_OPPOSITE,
		CFG_ROW_TOTAL,
		CFG_COLUMN_TOTAL
	} cfg_index_t;

	typedef struct packed {
		logic [CNT_W-1:0] rows;
		logic [CNT_W-1:0] cols;
	} grid_size_t;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             last;
	} job_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_LERP,
		ST_HOLD
	} back_state_t;

	// order of the six interpolations of one point
	typedef enum logic [2:0] {
		STEP_SX,
		STEP_SY,
		STEP_EX,
		STEP_EY,
		STEP_X,
		STEP_Y
	} lerp_step_t;

	// zero counts as one, anything above the maximum as the maximum
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] total,
			input int unsigned max_count);
		logic [CNT_W-1:0] res;
		if (total == '0) begin
			res = CNT_W'(1);
		end else if (32'(total) > max_count) begin
			res = CNT_W'(max_count);
		end else begin
			res = total;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sgpg_fifo.sv
// Short job queue between the position front end and the arithmetic back end.
// Uses sgpg_pkg for its default depth.
`default_nettype none

module sgpg_fifo import sgpg_pkg::*; #(
	parameter int WIDTH = 1,
	parameter int DEPTH = JOB_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  pop_valid,
	output logic [WIDTH-1:0]      pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W_Q = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]   mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W_Q-1:0] count_q;

	assign full      = (count_q == CNT_W_Q'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W_Q'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W_Q'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W_Q'(DEPTH))
		else $error("job queue count above depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("push into full job queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid)
		else $error("pop from empty job queue");

endmodule

`default_nettype wire

FILE: hw/rtl/sgpg_front.sv
// Front end: takes request beats, keeps the serpentine position and queues jobs.
// Uses sgpg_pkg (job_t, grid_size_t).
`default_nettype none

module sgpg_front import sgpg_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       restart,
	input  wire grid_size_t size,
	output logic            job_push,
	output job_t            job_data,
	input  wire logic       job_full
);

	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] visit_q;

	logic             wrap;
	logic [IDX_W-1:0] r;
	logic [IDX_W-1:0] v;
	logic [CNT_W-1:0] rows_m1;
	logic [CNT_W-1:0] cols_m1;
	logic [CNT_W-1:0] col_full;
	logic [CNT_W-1:0] v_inc;
	logic [CNT_W-1:0] r_inc;
	logic [IDX_W-1:0] r_nxt;
	logic [IDX_W-1:0] v_nxt;

	assign in_stall = job_full;
	assign job_push = in_valid && !job_full;

	always_comb begin
		// restart, or a position left outside a shrunk grid, starts over
		wrap = restart || (CNT_W'(row_q) >= size.rows) || (CNT_W'(visit_q) >= size.cols);
		r    = wrap ? '0 : row_q;
		v    = wrap ? '0 : visit_q;

		rows_m1  = size.rows - CNT_W'(1);
		cols_m1  = size.cols - CNT_W'(1);
		col_full = r[0] ? (cols_m1 - CNT_W'(v)) : CNT_W'(v);

		job_data.row  = r;
		job_data.col  = col_full[IDX_W-1:0];
		job_data.last = (CNT_W'(r) == rows_m1) && (CNT_W'(v) == cols_m1);

		v_inc = CNT_W'(v) + CNT_W'(1);
		r_inc = CNT_W'(r) + CNT_W'(1);
		if (v_inc >= size.cols) begin
			v_nxt = '0;
			r_nxt = (r_inc >= size.rows) ? '0 : r_inc[IDX_W-1:0];
		end else begin
			v_nxt = v_inc[IDX_W-1:0];
			r_nxt = r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			visit_q <= '0;
		end else if (job_push) begin
			row_q   <= r_nxt;
			visit_q <= v_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/sgpg_div.sv
// Radix-4 restoring divider for one grid factor: round(idx * 32768 / den).
// Two quotient bits per cycle. Uses sgpg_pkg widths.
`default_nettype none

module sgpg_div import sgpg_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [IDX_W-1:0] idx,
	input  wire logic [IDX_W-1:0] den,
	output logic                  busy,
	output logic [FACTOR_W-1:0]   quot
);

	localparam int DIV_W  = IDX_W + 1;
	localparam int STEPS  = FACTOR_W / 2;
	localparam int STEP_W = $clog2(STEPS);

	logic              busy_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dvs_q;
	logic [FACTOR_W-1:0] low_q;
	logic [FACTOR_W-1:0] quot_q;

	logic [DIV_W:0]   t1;
	logic [DIV_W:0]   t2;
	logic             ge1;
	logic             ge2;
	logic [DIV_W-1:0] r1;
	logic [DIV_W-1:0] r2;

	assign busy = busy_q;
	assign quot = quot_q;

	// numerator is idx * 65536 + den, divisor 2 * den
	always_comb begin
		t1  = {rem_q, low_q[FACTOR_W-1]};
		ge1 = (t1 >= {1'b0, dvs_q});
		r1  = ge1 ? DIV_W'(t1 - {1'b0, dvs_q}) : t1[DIV_W-1:0];
		t2  = {r1, low_q[FACTOR_W-2]};
		ge2 = (t2 >= {1'b0, dvs_q});
		r2  = ge2 ? DIV_W'(t2 - {1'b0, dvs_q}) : t2[DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + STEP_W'(1);
			if (cnt_q == STEP_W'(STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= DIV_W'(idx);
			dvs_q  <= {den, 1'b0};
			low_q  <= FACTOR_W'(den);
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= r2;
			low_q  <= {low_q[FACTOR_W-3:0], 2'b00};
			quot_q <= {quot_q[FACTOR_W-3:0], ge1, ge2};
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/sgpg_back.sv
// Back end: per job computes both factors, runs six interpolations on one
// shared multiplier and parks the point in the output register.
// Uses sgpg_pkg and instantiates sgpg_div twice.
`default_nettype none

module sgpg_back import sgpg_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            job_valid,
	input  wire job_t                            job_data,
	output logic                                 job_pop,
	input  wire grid_size_t                      size,
	input  wire logic [3:0][2*COORD_WIDTH-1:0]   corners,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic signed [COORD_WIDTH-1:0]        point_x,
	output logic signed [COORD_WIDTH-1:0]        point_y,
	output logic [CNT_W-1:0]                     row_number,
	output logic [CNT_W-1:0]                     column_number,
	output logic                                 final_point
);

	localparam int CW     = COORD_WIDTH;
	localparam int PROD_W = CW + FACTOR_W + 2;
	localparam int SUM_W  = PROD_W - FACTOR_FRAC;

	back_state_t state_q;
	back_state_t state_nxt;
	lerp_step_t  step_q;
	logic        phase_q;
	job_t        job_q;

	logic signed [PROD_W-1:0] prod_q;
	logic signed [CW-1:0]     a_q;
	logic signed [CW-1:0]     sx_q;
	logic signed [CW-1:0]     sy_q;
	logic signed [CW-1:0]     ex_q;
	logic signed [CW-1:0]     ey_q;
	logic signed [CW-1:0]     x_q;
	// last interpolation result waits in a register of its own
	logic signed [CW-1:0]     y_q;

	logic              out_valid_q;
	logic signed [CW-1:0] point_x_q;
	logic signed [CW-1:0] point_y_q;
	logic [CNT_W-1:0]  row_number_q;
	logic [CNT_W-1:0]  column_number_q;
	logic              final_point_q;

	logic              div_start;
	logic              mul_en;
	logic              fin_en;
	logic              out_free;
	logic              out_load;

	logic              row_busy;
	logic              col_busy;
	logic [FACTOR_W-1:0] row_quot;
	logic [FACTOR_W-1:0] col_quot;
	logic [CNT_W-1:0]  rows_m1;
	logic [CNT_W-1:0]  cols_m1;
	logic [FACTOR_W-1:0] fr;
	logic [FACTOR_W-1:0] fc;

	logic signed [CW-1:0]       a_sel;
	logic signed [CW-1:0]       b_sel;
	logic [FACTOR_W-1:0]        f_sel;
	logic signed [CW:0]         diff;
	logic signed [FACTOR_W:0]   f_s;
	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W-1:0]   rnd;
	logic signed [PROD_W-1:0]   shifted;
	logic [SUM_W-1:0]           sum;
	logic [3:0]                 top;
	logic signed [CW-1:0]       res;

	assign rows_m1 = size.rows - CNT_W'(1);
	assign cols_m1 = size.cols - CNT_W'(1);

	sgpg_div u_div_row (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.idx    (job_data.row),
		.den    (rows_m1[IDX_W-1:0]),
		.busy   (row_busy),
		.quot   (row_quot)
	);

	sgpg_div u_div_col (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.idx    (job_data.col),
		.den    (cols_m1[IDX_W-1:0]),
		.busy   (col_busy),
		.quot   (col_quot)
	);

	// a single row or column sits at one half
	assign fr = (rows_m1 == '0) ? FACTOR_W'(FACTOR_HALF) : row_quot;
	assign fc = (cols_m1 == '0) ? FACTOR_W'(FACTOR_HALF) : col_quot;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:   if (job_valid) state_nxt = ST_DIVIDE;
			ST_DIVIDE: if (!row_busy) state_nxt = ST_LERP;
			ST_LERP:   if (phase_q && step_q == STEP_Y) state_nxt = ST_HOLD;
			ST_HOLD:   if (out_free) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		job_pop   = 1'b0;
		div_start = 1'b0;
		mul_en    = 1'b0;
		fin_en    = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				job_pop   = job_valid;
				div_start = job_valid;
			end
			ST_DIVIDE: ;
			ST_LERP: begin
				mul_en = !phase_q;
				fin_en = phase_q;
			end
			ST_HOLD: begin
				out_load = out_free;
			end
			default: ;
		endcase
	end

	// operand select: row start/end points first, then the column blend
	always_comb begin
		case (step_q)
			STEP_SX: begin
				a_sel = corners[0][2*CW-1:CW];
				b_sel = corners[1][2*CW-1:CW];
				f_sel = fr;
			end
			STEP_SY: begin
				a_sel = corners[0][CW-1:0];
				b_sel = corners[1][CW-1:0];
				f_sel = fr;
			end
			STEP_EX: begin
				a_sel = corners[2][2*CW-1:CW];
				b_sel = corners[3][2*CW-1:CW];
				f_sel = fr;
			end
			STEP_EY: begin
				a_sel = corners[2][CW-1:0];
				b_sel = corners[3][CW-1:0];
				f_sel = fr;
			end
			STEP_X: begin
				a_sel = sx_q;
				b_sel = ex_q;
				f_sel = fc;
			end
			STEP_Y: begin
				a_sel = sy_q;
				b_sel = ey_q;
				f_sel = fc;
			end
			default: begin
				a_sel = sx_q;
				b_sel = ex_q;
				f_sel = fc;
			end
		endcase
	end

	always_comb begin
		diff = {b_sel[CW-1], b_sel} - {a_sel[CW-1], a_sel};
		f_s  = {1'b0, f_sel};
		prod = diff * f_s;

		// round half up, floor shift, then saturate to the coordinate range
		rnd     = prod_q + PROD_W'(FACTOR_HALF);
		shifted = rnd >>> FACTOR_FRAC;
		sum     = {{(SUM_W - CW){a_q[CW-1]}}, a_q} + shifted[SUM_W-1:0];
		top     = sum[CW+2:CW-1];
		if (top == 4'b0000 || top == 4'b1111) begin
			res = sum[CW-1:0];
		end else if (sum[SUM_W-1]) begin
			res = {1'b1, {(CW-1){1'b0}}};
		end else begin
			res = {1'b0, {(CW-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_SX;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_DIVIDE) begin
				step_q  <= STEP_SX;
				phase_q <= 1'b0;
			end else if (state_q == ST_LERP) begin
				phase_q <= !phase_q;
				if (phase_q && step_q != STEP_Y) begin
					step_q <= lerp_step_t'(step_q + 3'd1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job_data;
		end
		if (mul_en) begin
			prod_q <= prod;
			a_q    <= a_sel;
		end
		if (fin_en) begin
			case (step_q)
				STEP_SX: sx_q <= res;
				STEP_SY: sy_q <= res;
				STEP_EX: ex_q <= res;
				STEP_EY: ey_q <= res;
				STEP_X:  x_q  <= res;
				default: y_q  <= res;
			endcase
		end
		if (out_load) begin
			point_x_q       <= x_q;
			point_y_q       <= y_q;
			row_number_q    <= CNT_W'(job_q.row) + CNT_W'(1);
			column_number_q <= CNT_W'(job_q.col) + CNT_W'(1);
			final_point_q   <= job_q.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign point_x       = point_x_q;
	assign point_y       = point_y_q;
	assign row_number    = row_number_q;
	assign column_number = column_number_q;
	assign final_point   = final_point_q;

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		row_busy == col_busy)
		else $error("row and column dividers out of step");
	a_lerp_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LERP |-> !row_busy && !col_busy)
		else $error("interpolation started before factors were ready");
	a_hold_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HOLD && out_valid_q && out_stall) |=> state_q == ST_HOLD)
		else $error("finished point dropped while output stalled");

endmodule

`default_nettype wire

FILE: hw/rtl/serpentine_grid_point_generator.sv
// Serpentine grid point generator. Each request beat (restart = 1 starts over at the
// first grid point, 0 moves on) yields one result beat with a bilinearly interpolated
// point (signed, 8 fraction bits), its one-based row and column and a flag on the last
// point; even rows run left to right, odd rows right to left, and the grid wraps after
// its last point. In the back end a point is handled in steps: fetch the job, run the
// two radix-4 factor dividers side by side, do six interpolations on one shared
// multiplier (each a multiply, then round and saturate) and hand over to the output
// register. The front end queues up to two positions, so requests are taken while the
// back end works and while a result waits, until the queue is full. The user is to
// write registers only while the block is idle; the block does not enforce this.
// Depends on sgpg_pkg, sgpg_front, sgpg_fifo, sgpg_back (which uses sgpg_div).
`default_nettype none

module serpentine_grid_point_generator import sgpg_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_write,
	input  wire logic [CFG_INDEX_W-1:0]       cfg_index,
	input  wire logic [2*COORD_WIDTH-1:0]     cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         restart,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [COORD_WIDTH-1:0]     point_x,
	output logic signed [COORD_WIDTH-1:0]     point_y,
	output logic [CNT_W-1:0]                  row_number,
	output logic [CNT_W-1:0]                  column_number,
	output logic                              final_point
);

	logic [3:0][2*COORD_WIDTH-1:0] corner_q;
	logic [CNT_W-1:0]              row_total_q;
	logic [CNT_W-1:0]              column_total_q;
	grid_size_t                    size;

	logic job_push;
	job_t job_in;
	logic job_full;
	logic job_pop;
	logic job_valid;
	job_t job_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q       <= '0;
			row_total_q    <= CNT_W'(1);
			column_total_q <= CNT_W'(1);
		end else if (cfg_write) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_ORIGIN:       corner_q[0]    <= cfg_data;
				CFG_ROW_END:      corner_q[1]    <= cfg_data;
				CFG_COLUMN_END:   corner_q[2]    <= cfg_data;
				CFG_OPPOSITE:     corner_q[3]    <= cfg_data;
				CFG_ROW_TOTAL:    row_total_q    <= cfg_data[CNT_W-1:0];
				CFG_COLUMN_TOTAL: column_total_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign size.rows = eff_count(row_total_q, MAX_ROWS);
	assign size.cols = eff_count(column_total_q, MAX_COLUMNS);

	sgpg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.restart  (restart),
		.size     (size),
		.job_push (job_push),
		.job_data (job_in),
		.job_full (job_full)
	);

	sgpg_fifo #(
		.WIDTH ($bits(job_t)),
		.DEPTH (JOB_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_in),
		.full      (job_full),
		.pop       (job_pop),
		.pop_valid (job_valid),
		.pop_data  (job_out)
	);

	sgpg_back #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (job_valid),
		.job_data      (job_out),
		.job_pop       (job_pop),
		.size          (size),
		.corners       (corner_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.point_x       (point_x),
		.point_y       (point_y),
		.row_number    (row_number),
		.column_number (column_number),
		.final_point   (final_point)
	);

endmodule

`default_nettype wire
